[hdl/fir_pkg.sv]
// shared constants, codes and controller/datapath interface types for the q15 fir filter
package fir_pkg;

  localparam int TAPS     = 81;
  localparam int ADDR_W   = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int DATA_W   = 16;
  localparam int IDX_W    = 7;
  localparam int PROD_W   = 2 * DATA_W;
  localparam int ACC_W    = PROD_W + ADDR_W;
  localparam int FRAC_W   = 15;
  localparam int Q_W      = ACC_W - FRAC_W;
  localparam int FUNC_W   = 2;
  localparam int TDATA_W  = ((IDX_W + 2 * DATA_W + 7) / 8) * 8;

  // tdata field positions
  localparam int IDX_LSB    = 0;
  localparam int COEFF_LSB  = IDX_LSB + IDX_W;
  localparam int SAMPLE_LSB = COEFF_LSB + DATA_W;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOAD   = 2'd0,
    FUNC_SAMPLE = 2'd1,
    FUNC_CLEAR  = 2'd2
  } fir_func_t;

  typedef struct packed {
    logic load;       // write one coefficient
    logic sample_wr;  // store newest sample, start a new sum
    logic clear;      // drop delay line history and position
    logic step;       // issue one tap read pair
    logic abs_en;     // capture accumulator magnitude and sign
    logic emit;       // round, saturate and load the output word
  } fir_cmd_t;

  typedef struct packed {
    logic last;       // final tap being issued
    logic busy;       // reads or products still in flight
    logic out_free;   // output register can take a word
  } fir_sts_t;

endpackage

[hdl/fir_q15_filter.sv]
// top level of the direct-form q15 fir filter
//
//  channel | dir | tdata                                        | tuser
//  s_axis  | in  | coeff_index, coeff_value, sample             | func
//  m_axis  | out | filtered                                     | -
//
// a coefficient load or a clear word leaves the block ready again in the next cycle
// a sample word runs one multiply-accumulate per tap, bounded by the single read port
//   of each tap and delay memory, then pipeline drain, magnitude capture and the
//   rounding/output step; no new word is taken until that step is done
// sync reset zeroes all taps and history at once through per-entry valid bits, no sweep
// a stalled output word holds; a finished sum waits in the emit step until the output frees
module fir_q15_filter (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // [6:0] coeff_index, [22:7] coeff_value, [38:23] sample, [39] zero
  input  logic [fir_pkg::TDATA_W-1:0]  s_axis_tdata,
  // [1:0] func: load coefficient, filter sample, clear delay line
  input  logic [fir_pkg::FUNC_W-1:0]   s_axis_tuser,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // [15:0] filtered
  output logic [fir_pkg::DATA_W-1:0]   m_axis_tdata
);

  fir_pkg::fir_cmd_t cmd;
  fir_pkg::fir_sts_t sts;

  // controller owns the handshake and the per-item sequence
  fir_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_axis_tvalid),
    .s_tready (s_axis_tready),
    .s_tuser  (s_axis_tuser),
    .cmd      (cmd),
    .sts      (sts)
  );

  // datapath holds memories, mac pipe and the output word register
  fir_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .in_tdata (s_axis_tdata),
    .m_tvalid (m_axis_tvalid),
    .m_tready (m_axis_tready),
    .m_tdata  (m_axis_tdata)
  );

endmodule

[hdl/fir_ram.sv]
// generic single write port, single read port ram with registered read
module fir_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 81
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic                             re,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/fir_datapath.sv]
// fir datapath: tap and delay memories, multiply-accumulate, rounding and output register
module fir_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  fir_pkg::fir_cmd_t             cmd,
  output fir_pkg::fir_sts_t             sts,
  input  logic [fir_pkg::TDATA_W-1:0]   in_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [fir_pkg::DATA_W-1:0]    m_tdata
);

  logic [fir_pkg::IDX_W-1:0]         coeff_index;
  logic [fir_pkg::DATA_W-1:0]        coeff_value;
  logic [fir_pkg::DATA_W-1:0]        sample;
  logic                              idx_ok;

  logic [fir_pkg::TAPS-1:0]          tap_valid;
  logic [fir_pkg::TAPS-1:0]          dly_valid;
  logic [fir_pkg::ADDR_W-1:0]        wpos;
  logic [fir_pkg::ADDR_W-1:0]        k;
  logic [fir_pkg::ADDR_W-1:0]        p;

  logic                              rd_v;
  logic                              prod_v;
  logic                              tap_vq;
  logic                              dly_vq;
  logic [fir_pkg::DATA_W-1:0]        tap_rdata;
  logic [fir_pkg::DATA_W-1:0]        dly_rdata;
  logic signed [fir_pkg::DATA_W-1:0] tap_m;
  logic signed [fir_pkg::DATA_W-1:0] dly_m;
  logic signed [fir_pkg::PROD_W-1:0] prod;
  logic signed [fir_pkg::ACC_W-1:0]  acc;
  logic [fir_pkg::ACC_W-1:0]         mag;
  logic                              neg;
  logic [fir_pkg::ACC_W-1:0]         mag_rnd;
  logic [fir_pkg::Q_W-1:0]           q;
  logic [fir_pkg::DATA_W-1:0]        sat;

  assign coeff_index = in_tdata[fir_pkg::IDX_LSB +: fir_pkg::IDX_W];
  assign coeff_value = in_tdata[fir_pkg::COEFF_LSB +: fir_pkg::DATA_W];
  assign sample      = in_tdata[fir_pkg::SAMPLE_LSB +: fir_pkg::DATA_W];
  assign idx_ok      = 32'(coeff_index) < fir_pkg::TAPS;

  fir_ram #(
    .WIDTH (fir_pkg::DATA_W),
    .DEPTH (fir_pkg::TAPS)
  ) u_tap_ram (
    .clk   (clk),
    .we    (cmd.load && idx_ok),
    .waddr (fir_pkg::ADDR_W'(coeff_index)),
    .wdata (coeff_value),
    .re    (cmd.step),
    .raddr (k),
    .rdata (tap_rdata)
  );

  fir_ram #(
    .WIDTH (fir_pkg::DATA_W),
    .DEPTH (fir_pkg::TAPS)
  ) u_dly_ram (
    .clk   (clk),
    .we    (cmd.sample_wr),
    .waddr (wpos),
    .wdata (sample),
    .re    (cmd.step),
    .raddr (p),
    .rdata (dly_rdata)
  );

  // entries never written read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      tap_valid <= '0;
      dly_valid <= '0;
      wpos      <= '0;
    end else begin
      if (cmd.load && idx_ok) begin
        tap_valid[fir_pkg::ADDR_W'(coeff_index)] <= 1'b1;
      end
      if (cmd.clear) begin
        dly_valid <= '0;
        wpos      <= '0;
      end else begin
        if (cmd.sample_wr) begin
          dly_valid[wpos] <= 1'b1;
        end
        if (cmd.emit) begin
          wpos <= (32'(wpos) == fir_pkg::TAPS - 1) ? '0 : wpos + 1'b1;
        end
      end
    end
  end

  // tap counter walking forward from tap 0, delay pointer walking backward from the newest sample
  always_ff @(posedge clk) begin
    if (cmd.sample_wr) begin
      k <= '0;
      p <= wpos;
    end else if (cmd.step) begin
      k <= k + 1'b1;
      p <= (p == '0) ? fir_pkg::ADDR_W'(fir_pkg::TAPS - 1) : p - 1'b1;
    end
    if (cmd.step) begin
      tap_vq <= tap_valid[k];
      dly_vq <= dly_valid[p];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v   <= 1'b0;
      prod_v <= 1'b0;
    end else begin
      rd_v   <= cmd.step;
      prod_v <= rd_v;
    end
  end

  assign tap_m = tap_vq ? $signed(tap_rdata) : '0;
  assign dly_m = dly_vq ? $signed(dly_rdata) : '0;

  always_ff @(posedge clk) begin
    prod <= tap_m * dly_m;
    if (cmd.sample_wr) begin
      acc <= '0;
    end else if (prod_v) begin
      acc <= acc + fir_pkg::ACC_W'(prod);
    end
    if (cmd.abs_en) begin
      neg <= acc[fir_pkg::ACC_W-1];
      mag <= acc[fir_pkg::ACC_W-1] ? fir_pkg::ACC_W'(-acc) : fir_pkg::ACC_W'(acc);
    end
  end

  // round half away from zero on the magnitude, then saturate
  assign mag_rnd = mag + (fir_pkg::ACC_W'(1) << (fir_pkg::FRAC_W - 1));
  assign q       = mag_rnd[fir_pkg::ACC_W-1:fir_pkg::FRAC_W];

  always_comb begin
    if (neg) begin
      if (q > fir_pkg::Q_W'(32768)) begin
        sat = 16'h8000;
      end else begin
        sat = fir_pkg::DATA_W'(-q);
      end
    end else begin
      if (q > fir_pkg::Q_W'(32767)) begin
        sat = 16'h7fff;
      end else begin
        sat = q[fir_pkg::DATA_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (cmd.emit) begin
      m_tdata <= sat;
    end
  end

  assign sts.last     = 32'(k) == fir_pkg::TAPS - 1;
  assign sts.busy     = rd_v | prod_v;
  assign sts.out_free = !m_tvalid || m_tready;

endmodule

[hdl/fir_ctrl.sv]
// fir controller: sequences load, clear and the per-sample multiply-accumulate pass
module fir_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [fir_pkg::FUNC_W-1:0]  s_tuser,
  output fir_pkg::fir_cmd_t           cmd,
  input  fir_pkg::fir_sts_t           sts
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_MAC   = 4'b0010,
    S_DRAIN = 4'b0100,
    S_EMIT  = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign s_tready = state == S_IDLE;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          unique case (s_tuser)
            fir_pkg::FUNC_LOAD: begin
              cmd.load = 1'b1;
            end
            fir_pkg::FUNC_SAMPLE: begin
              cmd.sample_wr = 1'b1;
              state_next    = S_MAC;
            end
            fir_pkg::FUNC_CLEAR: begin
              cmd.clear = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      S_MAC: begin
        cmd.step = 1'b1;
        if (sts.last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // wait for the last product to land in the accumulator
        if (!sts.busy) begin
          cmd.abs_en = 1'b1;
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

[hdl/fir_checker.sv]
// port-level checks for the q15 fir filter and their bind
module fir_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        s_axis_tvalid,
  input logic                        s_axis_tready,
  input logic [fir_pkg::FUNC_W-1:0]  s_axis_tuser,
  input logic                        m_axis_tvalid,
  input logic                        m_axis_tready,
  input logic [fir_pkg::DATA_W-1:0]  m_axis_tdata
);

  logic in_acc;

  assign in_acc = s_axis_tvalid && s_axis_tready;

  // stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word changed under stall");

  // reset leaves the block ready with no pending output
  a_reset: assert property (@(posedge clk)
    rst |=> s_axis_tready && !m_axis_tvalid)
    else $error("bad state after reset");

  // load, clear and unused words leave the input ready again on the next cycle
  a_short: assert property (@(posedge clk) disable iff (rst)
    in_acc && s_axis_tuser != fir_pkg::FUNC_SAMPLE |=> s_axis_tready)
    else $error("non-sample word held the input");

  // a sample word occupies the block and gives no immediate output
  a_sample_busy: assert property (@(posedge clk) disable iff (rst)
    in_acc && s_axis_tuser == fir_pkg::FUNC_SAMPLE |=> !s_axis_tready && !$rose(m_axis_tvalid))
    else $error("sample word not sequenced");

endmodule

bind fir_q15_filter fir_checker u_fir_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

[tb/fir_q15_filter_test.sv]
// self-checking stream testbench for the q15 direct-form fir filter
`timescale 1ns / 1ps

module fir_q15_filter_test;

  localparam int          CLK_HALF     = 6;
  localparam int          RESET_CYCLES = 6;
  localparam int          RANDOM_WORDS = 580;
  localparam int          LONG_HOLD    = 800;
  localparam int          LIMIT_CYCLES = 600000;
  localparam int          DRAIN_CYCLES = fir_pkg::TAPS + 32;
  localparam int          MAX_INDEX    = (1 << fir_pkg::IDX_W) - 1;
  localparam logic [fir_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam longint      Q15_HALF     = 64'sd16384;
  localparam longint      Q15_ONE      = 64'sd32768;
  localparam longint      Q15_MAX      = 64'sd32767;
  localparam longint      Q15_MIN      = -64'sd32768;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         s_axis_tvalid = 1'b0;
  logic                         s_axis_tready;
  logic [fir_pkg::TDATA_W-1:0]  s_axis_tdata = '0;
  logic [fir_pkg::FUNC_W-1:0]   s_axis_tuser = '0;
  logic                         m_axis_tvalid;
  logic                         m_axis_tready = 1'b0;
  logic [fir_pkg::DATA_W-1:0]   m_axis_tdata;

  // mirror of the filter state
  logic signed [fir_pkg::DATA_W-1:0] coeffs [fir_pkg::TAPS];
  logic signed [fir_pkg::DATA_W-1:0] hist [fir_pkg::TAPS];
  int                                wpos;
  logic [fir_pkg::DATA_W-1:0]        pending_filtered [$];

  int          mismatches = 0;
  int          cycle_count = 0;
  int          burst_left = 0;
  // long output hold requested by the stimulus, served by the receiver
  int          hold_asked = 0;
  int          hold_given = 0;
  int          hold_left = 0;
  int          stall_mode = 0;
  int          stall_left = 0;
  logic [fir_pkg::DATA_W-1:0] want;

  fir_q15_filter dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #(CLK_HALF) clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // q30 sum to q15: halves away from zero, then clamp
  function automatic logic [fir_pkg::DATA_W-1:0] round_sat_q15(input longint acc);
    longint q;
    if (acc >= 0)
      q = (acc + Q15_HALF) / Q15_ONE;
    else
      q = -((-acc + Q15_HALF) / Q15_ONE);
    if (q > Q15_MAX)
      q = Q15_MAX;
    else if (q < Q15_MIN)
      q = Q15_MIN;
    return q[fir_pkg::DATA_W-1:0];
  endfunction

  // update the mirrored state for one accepted word, queue its output if any
  task automatic track_word(input logic [fir_pkg::FUNC_W-1:0] fn,
                            input logic [fir_pkg::IDX_W-1:0] idx,
                            input logic [fir_pkg::DATA_W-1:0] cval,
                            input logic [fir_pkg::DATA_W-1:0] smp);
    longint acc;
    int     p;
    case (fn)
      fir_pkg::FUNC_LOAD: begin
        if (idx < fir_pkg::TAPS)
          coeffs[idx] = cval;
      end
      fir_pkg::FUNC_CLEAR: begin
        foreach (hist[i]) hist[i] = '0;
        wpos = 0;
      end
      fir_pkg::FUNC_SAMPLE: begin
        hist[wpos] = smp;
        acc = 0;
        p = wpos;
        for (int k = 0; k < fir_pkg::TAPS; k++) begin
          acc += longint'(coeffs[k]) * longint'(hist[p]);
          p = (p == 0) ? fir_pkg::TAPS - 1 : p - 1;
        end
        wpos = (wpos + 1 == fir_pkg::TAPS) ? 0 : wpos + 1;
        pending_filtered.push_back(round_sat_q15(acc));
      end
      default: ;
    endcase
  endtask

  // offer one word, with random gaps between bursts
  task automatic send_word(input logic [fir_pkg::FUNC_W-1:0] fn,
                           input logic [fir_pkg::IDX_W-1:0] idx,
                           input logic [fir_pkg::DATA_W-1:0] cval,
                           input logic [fir_pkg::DATA_W-1:0] smp);
    logic [fir_pkg::TDATA_W-1:0] word;
    int                          gap;
    word = '0;
    word[fir_pkg::IDX_LSB +: fir_pkg::IDX_W] = idx;
    word[fir_pkg::COEFF_LSB +: fir_pkg::DATA_W] = cval;
    word[fir_pkg::SAMPLE_LSB +: fir_pkg::DATA_W] = smp;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) == 0)
        gap = 0;
      else
        gap = $urandom_range(1, ($urandom_range(0, 4) == 0) ? 100 : 12);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= word;
    s_axis_tuser <= fn;
    do @(posedge clk); while (!s_axis_tready);
    burst_left--;
    track_word(fn, idx, cval, smp);
  endtask

  function automatic logic [fir_pkg::DATA_W-1:0] pick_coeff();
    case ($urandom_range(0, 7))
      0: return 16'($urandom);
      1: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
      default: return 16'($urandom_range(0, 4095) - 2048);
    endcase
  endfunction

  function automatic logic [fir_pkg::DATA_W-1:0] pick_sample();
    case ($urandom_range(0, 15))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  // output side: a long hold on request, otherwise a changing stall pattern
  always @(posedge clk) begin
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_asked != hold_given) begin
      m_axis_tready <= 1'b0;
      hold_given <= hold_given + 1;
      hold_left <= LONG_HOLD;
    end else begin
      if (stall_left == 0) begin
        stall_mode <= $urandom_range(0, 2);
        stall_left <= $urandom_range(50, 400);
      end else begin
        stall_left <= stall_left - 1;
      end
      case (stall_mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= 1'($urandom_range(0, 1));
        default: m_axis_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // compare each output word against the oldest pending value
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_filtered.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected output word: expected none actual %0d",
                   $signed(m_axis_tdata));
        mismatches++;
      end else begin
        want = pending_filtered.pop_front();
        if (m_axis_tdata !== want) begin
          if (mismatches < 10)
            $display("filtered mismatch: expected %0d actual %0d",
                     $signed(want), $signed(m_axis_tdata));
          mismatches++;
        end
      end
    end
  end

  // all-zero taps after reset give zero at the sample extremes
  task automatic test_zero_taps();
    send_word(fir_pkg::FUNC_SAMPLE, '0, '0, 16'h7fff);
    send_word(fir_pkg::FUNC_SAMPLE, 7'h7f, 16'hffff, 16'h8000);
  endtask

  // unit tap: exact halves round away from zero, just below half rounds to zero
  task automatic test_rounding_halves();
    send_word(fir_pkg::FUNC_LOAD, 7'd0, 16'd1, '0);
    send_word(fir_pkg::FUNC_SAMPLE, '0, '0, 16'sd16384);
    send_word(fir_pkg::FUNC_SAMPLE, '0, '0, -16'sd16384);
    send_word(fir_pkg::FUNC_SAMPLE, '0, '0, 16'sd16383);
    send_word(fir_pkg::FUNC_SAMPLE, '0, '0, -16'sd16383);
    send_word(fir_pkg::FUNC_SAMPLE, '0, '0, 16'h7fff);
    send_word(fir_pkg::FUNC_SAMPLE, '0, '0, 16'h8000);
  endtask

  // full-scale products drive the sum past both ends of the range
  task automatic test_saturation();
    send_word(fir_pkg::FUNC_LOAD, 7'd0, 16'h8000, '0);
    send_word(fir_pkg::FUNC_SAMPLE, '0, '0, 16'h8000);
    send_word(fir_pkg::FUNC_LOAD, 7'd1, 16'h8000, '0);
    send_word(fir_pkg::FUNC_SAMPLE, '0, '0, 16'h7fff);
    send_word(fir_pkg::FUNC_SAMPLE, '0, '0, 16'h7fff);
  endtask

  // last tap is writable, indexes past it are dropped
  task automatic test_index_bounds();
    send_word(fir_pkg::FUNC_LOAD, 7'(fir_pkg::TAPS - 1), 16'h7fff, '0);
    send_word(fir_pkg::FUNC_LOAD, 7'(fir_pkg::TAPS), 16'sd12345, '0);
    send_word(fir_pkg::FUNC_LOAD, 7'(MAX_INDEX), 16'hffff, '0);
  endtask

  // unused selector does nothing, clear drops history but keeps taps
  task automatic test_clear_and_unused();
    send_word(FUNC_UNUSED, 7'h7f, 16'hffff, 16'hffff);
    send_word(fir_pkg::FUNC_SAMPLE, 7'h7f, 16'hffff, 16'sd1000);
    send_word(fir_pkg::FUNC_CLEAR, 7'h7f, 16'hffff, 16'hffff);
    send_word(fir_pkg::FUNC_SAMPLE, '0, '0, -16'sd1000);
  endtask

  // mostly fresh tap tables and sample streams, some clears and ignored words
  task automatic test_random_traffic();
    int   done;
    int   r;
    logic held;
    done = 0;
    held = 1'b0;
    for (int k = 0; k < fir_pkg::TAPS; k++) begin
      send_word(fir_pkg::FUNC_LOAD, 7'(k), pick_coeff(), 16'($urandom));
      done++;
    end
    while (done < RANDOM_WORDS) begin
      // stop draining the output while samples keep coming
      if (!held && done >= 200) begin
        hold_asked++;
        held = 1'b1;
      end
      r = $urandom_range(0, 99);
      if (r < 25) begin
        send_word(fir_pkg::FUNC_LOAD, 7'($urandom_range(0, fir_pkg::TAPS - 1)),
                  pick_coeff(), 16'($urandom));
        done++;
      end else if (r < 29) begin
        send_word(fir_pkg::FUNC_LOAD, 7'($urandom_range(fir_pkg::TAPS, MAX_INDEX)),
                  16'($urandom), 16'($urandom));
      end else if (r < 31) begin
        send_word(fir_pkg::FUNC_CLEAR, 7'($urandom), 16'($urandom), 16'($urandom));
        done++;
      end else if (r < 33) begin
        send_word(FUNC_UNUSED, 7'($urandom), 16'($urandom), 16'($urandom));
      end else begin
        send_word(fir_pkg::FUNC_SAMPLE, 7'($urandom), 16'($urandom), pick_sample());
        done++;
      end
    end
  endtask

  initial begin
    foreach (coeffs[i]) coeffs[i] = '0;
    foreach (hist[i]) hist[i] = '0;
    wpos = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_zero_taps();
    test_rounding_halves();
    test_saturation();
    test_index_bounds();
    test_clear_and_unused();
    test_random_traffic();

    s_axis_tvalid <= 1'b0;
    while (pending_filtered.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    mismatches += pending_filtered.size();

    if (mismatches == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

[fir_q15_filter.f]
hdl/fir_pkg.sv
hdl/fir_ram.sv
hdl/fir_datapath.sv
hdl/fir_ctrl.sv
hdl/fir_q15_filter.sv
hdl/fir_checker.sv
tb/fir_q15_filter_test.sv
